FILE: rtl/segmented_prime_sieve_window_defines.svh
// Assertion macros shared by the RTL.
`ifndef SEGMENTED_PRIME_SIEVE_WINDOW_DEFINES_SVH
`define SEGMENTED_PRIME_SIEVE_WINDOW_DEFINES_SVH

// Assert that prop holds on every clock edge outside reset.
`define SPSW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that cond at one edge implies conseq at the next edge.
`define SPSW_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: rtl/spsw_pkg.sv
`timescale 1ns / 1ps
package spsw_pkg;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned WindowBits = 64;
  localparam int unsigned IndexW     = 26;
  localparam int unsigned LimitW     = 32;
  localparam int unsigned TotalW     = 7;
  localparam int unsigned PrimeW     = 16;
endpackage

FILE: rtl/spsw_if.sv
`timescale 1ns / 1ps
// Valid/ready channel with a generic payload.
interface spsw_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/spsw_ram.sv
`timescale 1ns / 1ps
// Single-port RAM with registered read.
module spsw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: rtl/segmented_prime_sieve_window.sv
`timescale 1ns / 1ps
// Segmented prime sieve over windows of 64 consecutive integers. After reset
// the block clears an odd-only bitmap of 2^15 entries (one entry a cycle),
// sieves it with one write per marked entry, then scans it into the prime
// table; in_if.ready stays low until this is done. Each item then walks the
// prime table: per prime a table read and check, a shared 33-step restoring
// divider for the remainder of the window base, a step to place the first
// multiple, and one step per cleared multiple, for every sieving prime with
// p*p at or below the window top; the walk ends at the first prime past that
// or at the end of the table. The mask is then trimmed and counted.
module segmented_prime_sieve_window #(
  parameter int unsigned TABLE_DEPTH = 8192
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [spsw_pkg::LimitW-1:0] cfg_wdata_i,
  spsw_if.sink                   in_if,
  spsw_if.source                 out_if
);
  import spsw_pkg::*;
  `include "segmented_prime_sieve_window_defines.svh"

  localparam int unsigned HalfBits = (ValueBits + 1) / 2;
  localparam int unsigned OddSlots = 2 ** (HalfBits - 1);
  localparam int unsigned OddAw    = HalfBits - 1;
  localparam int unsigned TabAw    = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW     = TabAw + 1;
  localparam int unsigned WideW    = 64;
  localparam int unsigned OffW     = $clog2(WindowBits);
  localparam int unsigned DivW     = IndexW + OffW + 1;
  localparam int unsigned DivStepW = $clog2(DivW + 1);
  localparam int unsigned PcW      = $clog2(WindowBits + 1);

  typedef enum logic [3:0] {
    StClear, StScan, StMark, StPush, StIdle, StRead, StWait,
    StCheck, StDiv, StCross, StPop, StOut
  } state_e;

  state_e state_q;
  logic [LimitW-1:0] limit_q;
  logic [OddAw:0] oi_q;
  logic [OddAw:0] om_q;
  logic [HalfBits:0] op_q;
  logic [1:0] ph_q;
  logic [CntW-1:0] cnt_q, k_q;
  logic [WindowBits-1:0] scr_q;
  logic [IndexW-1:0] idx_q;
  logic [WideW-1:0] base_q, top_q, p_q, pp_q, j_q;
  logic [DivW-1:0] rem_q, num_q;
  logic [DivStepW-1:0] dstep_q;
  logic [PcW-1:0] pc_q;
  logic [6:0] pci_q;
  logic [WindowBits-1:0] mask_q;
  logic out_valid_q;
  logic reach_q;

  // Odd bitmap RAM and prime table RAM.
  logic bm_we, bm_wd, bm_rd;
  logic [OddAw-1:0] bm_addr;
  logic tb_we;
  logic [TabAw-1:0] tb_addr;
  logic [PrimeW-1:0] tb_wd, tb_rd;

  spsw_ram #(.Width(1), .Depth(OddSlots)) u_bitmap (
    .clk_i, .we_i(bm_we), .addr_i(bm_addr), .wdata_i(bm_wd), .rdata_o(bm_rd)
  );
  spsw_ram #(.Width(PrimeW), .Depth(TABLE_DEPTH)) u_table (
    .clk_i, .we_i(tb_we), .addr_i(tb_addr), .wdata_i(tb_wd), .rdata_o(tb_rd)
  );

  // The first multiple at or above the base is the base rounded up by the remainder.
  logic [WideW-1:0] p_cur, rem_try, first_m;
  logic [DivW:0] rem_sh;
  logic [WindowBits-1:0] low_cut;
  assign p_cur   = WideW'(op_q) * 2 + 1;
  assign rem_sh  = {rem_q, num_q[DivW-1]};
  assign rem_try = WideW'(rem_sh) - p_q;
  assign first_m = base_q + ((rem_q != '0) ? (p_q - WideW'(rem_q)) : '0);
  assign low_cut = (base_q == '0) ? ~WindowBits'(3) : '1;

  always_comb begin
    bm_we = 1'b0; bm_wd = 1'b0; bm_addr = oi_q[OddAw-1:0];
    tb_we = 1'b0; tb_wd = PrimeW'(p_cur); tb_addr = k_q[TabAw-1:0];
    unique case (state_q)
      StClear: begin bm_we = 1'b1; bm_wd = 1'b1; end
      StMark:  begin bm_addr = om_q[OddAw-1:0]; bm_we = 1'b1; end
      StPush:  begin
        tb_addr = cnt_q[TabAw-1:0];
        tb_we = (ph_q == 2'd2) && (cnt_q < CntW'(TABLE_DEPTH)) &&
                ((oi_q == '0) || bm_rd);
        tb_wd = (oi_q == '0) ? PrimeW'(2) : PrimeW'(WideW'(oi_q) * 2 + 1);
      end
      default: ;
    endcase
  end

  assign in_if.ready  = (state_q == StIdle) && !out_valid_q;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = {mask_q, idx_q, TotalW'(pc_q), reach_q};

  // Sequencer for startup sieve and per-window sieve.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; limit_q <= '0; oi_q <= '0; om_q <= '0; op_q <= '0;
      ph_q <= '0; cnt_q <= '0; k_q <= '0; out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (out_if.valid && out_if.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        StClear: begin
          if (oi_q == (OddAw+1)'(OddSlots - 1)) begin
            state_q <= StScan; op_q <= (HalfBits+1)'(1); oi_q <= (OddAw+1)'(1);
            ph_q <= '0;
          end else oi_q <= oi_q + 1'b1;
        end
        StScan: begin
          // ph 0: address, 1: wait, 2: decide.
          if (ph_q != 2'd2) begin
            ph_q <= ph_q + 1'b1;
            oi_q <= op_q[OddAw:0];
          end else begin
            ph_q <= '0;
            if (p_cur * p_cur >= (WideW'(1) << HalfBits)) begin
              state_q <= StPush; oi_q <= '0; cnt_q <= '0;
            end else if (bm_rd) begin
              om_q <= (OddAw+1)'((p_cur * p_cur) >> 1); state_q <= StMark;
            end else op_q <= op_q + 1'b1;
          end
        end
        StMark: begin
          if (WideW'(om_q) + p_cur >= WideW'(OddSlots)) begin
            state_q <= StScan; op_q <= op_q + 1'b1;
          end else om_q <= (OddAw+1)'(WideW'(om_q) + p_cur);
        end
        StPush: begin
          if (ph_q != 2'd2) ph_q <= ph_q + 1'b1;
          else begin
            ph_q <= '0;
            if (tb_we) cnt_q <= cnt_q + 1'b1;
            if (oi_q == (OddAw+1)'(OddSlots - 1)) state_q <= StIdle;
            else oi_q <= oi_q + 1'b1;
          end
        end
        StIdle: begin
          if (in_if.valid && in_if.ready) begin
            idx_q  <= in_if.data;
            base_q <= WideW'(in_if.data) << OffW;
            top_q  <= (WideW'(in_if.data) << OffW) + WideW'(WindowBits - 1);
            scr_q  <= '1; k_q <= '0; state_q <= StRead;
          end
        end
        StRead: begin
          state_q <= (k_q >= cnt_q) ? StPop : StWait;
        end
        StWait: state_q <= StCheck;
        StCheck: begin
          p_q <= WideW'(tb_rd); pp_q <= WideW'(tb_rd) * WideW'(tb_rd);
          if (WideW'(tb_rd) * WideW'(tb_rd) > top_q) state_q <= StPop;
          else begin
            num_q <= DivW'(base_q); rem_q <= '0;
            dstep_q <= DivStepW'(DivW); state_q <= StDiv;
          end
        end
        StDiv: begin
          // Restoring remainder of the window base by p, one bit a cycle.
          if (dstep_q == '0) begin
            j_q <= (first_m < pp_q) ? pp_q : first_m;
            state_q <= StCross;
          end else begin
            num_q <= num_q << 1;
            dstep_q <= dstep_q - 1'b1;
            if (WideW'(rem_sh) >= p_q) begin
              rem_q <= DivW'(rem_try);
            end else begin
              rem_q <= DivW'(rem_sh);
            end
          end
        end
        StCross: begin
          if (j_q > top_q) begin
            k_q <= k_q + 1'b1; state_q <= StRead;
          end else begin
            scr_q[OffW'(j_q - base_q)] <= 1'b0;
            j_q <= j_q + p_q;
          end
        end
        StPop: begin
          // Apply the low and limit cuts, then count bits one a cycle.
          if (WideW'(limit_q) < base_q) scr_q <= '0;
          else if (WideW'(limit_q) < top_q)
            scr_q <= scr_q & ({WindowBits{1'b1}} >>
                     (OffW'(WindowBits - 1) - OffW'(WideW'(limit_q) - base_q))) &
                     low_cut;
          else scr_q <= scr_q & low_cut;
          reach_q <= top_q >= WideW'(limit_q);
          pc_q <= '0; pci_q <= '0; state_q <= StOut;
        end
        StOut: begin
          if (pci_q == 7'(WindowBits)) begin
            mask_q <= scr_q; out_valid_q <= 1'b1; state_q <= StIdle;
          end else begin
            pc_q <= pc_q + PcW'(scr_q[OffW'(pci_q)]);
            pci_q <= pci_q + 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `SPSW_ASSERT(a_ready_idle, clk_i, rst_ni, !in_if.ready || state_q == StIdle, "ready off idle")
  `SPSW_ASSERT(a_cnt_cap, clk_i, rst_ni, cnt_q <= CntW'(TABLE_DEPTH), "table count overflow")
  `SPSW_ASSERT_NEXT(a_accept, clk_i, rst_ni, in_if.valid && in_if.ready,
    state_q == StRead, "accept did not start walk")
endmodule

FILE: test/segmented_prime_sieve_window_tb.sv
`timescale 1ns / 1ps
module segmented_prime_sieve_window_tb;
  import spsw_pkg::*;

  localparam int unsigned StallLimit = 1500000;

  typedef logic [IndexW-1:0] window_t;
  typedef struct packed {
    logic [63:0]        prime_mask;
    logic [IndexW-1:0]  window_echo;
    logic [TotalW-1:0]  prime_total;
    logic               reaches_limit;
  } sieve_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [LimitW-1:0] cfg_wdata;

  spsw_if #(.payload_t(window_t))       win_if ();
  spsw_if #(.payload_t(sieve_result_t)) res_if ();

  segmented_prime_sieve_window u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (win_if),
    .out_if      (res_if)
  );

  // Model state: sieving primes, current limit, pending and expected items.
  int unsigned   small_primes[$];
  logic [LimitW-1:0] limit_copy;
  window_t       pending_windows[$];
  sieve_result_t expected_masks[$];
  int unsigned   mismatches = 0;
  int unsigned   idle_cycles = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Build every prime below 2^16 for use as a sieving prime.
  function automatic void build_small_primes();
    bit composite [65536];
    int unsigned i;
    int unsigned m;
    for (i = 2; i < 256; i++) begin
      if (!composite[i]) begin
        for (m = i * i; m < 65536; m += i) composite[m] = 1'b1;
      end
    end
    for (i = 2; i < 65536; i++) begin
      if (!composite[i]) small_primes.insert(small_primes.size(), i);
    end
  endfunction

  // Sieve one window of 64 integers against the current limit.
  function automatic sieve_result_t sieve_window(input window_t idx, input logic [31:0] lim);
    sieve_result_t r;
    longint unsigned base;
    longint unsigned top;
    longint unsigned p;
    longint unsigned first;
    longint unsigned j;
    longint unsigned l;
    logic [63:0] m;
    int unsigned cnt;
    base = longint'(idx) * 64;
    top  = base + 63;
    l    = lim;
    m    = '1;
    foreach (small_primes[k]) begin
      p = small_primes[k];
      if (p * p > top) break;
      first = ((base + p - 1) / p) * p;
      if (first < p * p) first = p * p;
      for (j = first; j <= top; j += p) m[j - base] = 1'b0;
    end
    if (base == 0) m[1:0] = 2'b00;
    if (l < base) m = '0;
    else if (l < top) m = m & ({64{1'b1}} >> (63 - (l - base)));
    cnt = 0;
    for (int b = 0; b < 64; b++) cnt += m[b];
    r.prime_mask    = m;
    r.window_echo   = idx;
    r.prime_total   = cnt[TotalW-1:0];
    r.reaches_limit = (top >= l);
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_if.valid <= 1'b0;
      win_if.data  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (win_if.valid && win_if.ready) begin
        expected_masks.insert(expected_masks.size(), sieve_window(win_if.data, limit_copy));
      end
      if (win_if.valid && !win_if.ready) begin
        // Hold the item until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        win_if.valid <= 1'b0;
      end else if (pending_windows.size() > 0) begin
        win_if.valid <= 1'b1;
        win_if.data  <= pending_windows.pop_front();
        if (burst_left == 0) burst_left = $urandom_range(1, 8);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      end else begin
        win_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: ready held high, random, or periodic, by a mode that is redrawn at random.
  int unsigned stall_tick;
  int unsigned stall_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_tick = 0;
      stall_mode = 0;
    end else begin
      stall_tick++;
      if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= 1'($urandom_range(0, 1));
        default: res_if.ready <= (stall_tick % 4 == 0);
      endcase
    end
  end

  // Checker: compare each taken result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_masks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", res_if.data);
      end else begin
        sieve_result_t want;
        want = expected_masks.pop_front();
        if (res_if.data !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("window %0d: expected mask %h echo %0d total %0d top %0d",
                     want.window_echo, want.prime_mask, want.window_echo,
                     want.prime_total, want.reaches_limit);
            $display("window %0d: actual   mask %h echo %0d total %0d top %0d",
                     want.window_echo, res_if.data.prime_mask, res_if.data.window_echo,
                     res_if.data.prime_total, res_if.data.reaches_limit);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any item moving.
  always @(posedge clk_i) begin
    if ((win_if.valid && win_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Wait until every item has been sent and every result has come back.
  task automatic drain();
    while (pending_windows.size() > 0 || win_if.valid || expected_masks.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [LimitW-1:0] value);
    @(posedge clk_i);
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    limit_copy = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Stimulus phases.
  initial begin
    int unsigned lim;
    int signed   near;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    rst_ni       = 1'b0;
    limit_copy   = '0;
    build_small_primes();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Limit left at its reset value: every mask is empty.
    pending_windows = '{window_t'(0), window_t'(1), window_t'(5)};
    drain();

    // Widest limit: zero and one, small windows and the top window.
    set_limit('1);
    pending_windows = '{window_t'(0), window_t'(1), window_t'(2), window_t'(3),
                        window_t'(1000), window_t'(4095), {IndexW{1'b1}}};
    drain();

    // Limit inside a window, below it and above it.
    set_limit(1000);
    pending_windows = '{window_t'(0), window_t'(14), window_t'(15), window_t'(16),
                        window_t'(17)};
    drain();

    set_limit(0);
    pending_windows = '{window_t'(0), window_t'(3)};
    drain();

    // Random limit with mostly small windows, some near the limit.
    lim = $urandom_range(0, 262143);
    set_limit(lim);
    for (int n = 0; n < 90; n++) begin
      if (n % 3 == 0) begin
        near = int'(lim / 64) + int'($urandom_range(0, 6)) - 3;
        if (near < 0) near = 0;
        pending_windows.insert(pending_windows.size(), window_t'(near));
      end else begin
        pending_windows.insert(pending_windows.size(), window_t'($urandom_range(0, 4095)));
      end
    end
    pending_windows.insert(pending_windows.size(),
                           window_t'($urandom_range(0, (1 << IndexW) - 1)));
    pending_windows.insert(pending_windows.size(),
                           window_t'($urandom_range(0, (1 << IndexW) - 1)));
    drain();

    // Limit inside the very last window.
    set_limit(32'hFFFF_FFDE);
    pending_windows = '{{IndexW{1'b1}}, window_t'(7)};
    drain();

    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_masks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/spsw_pkg.sv
rtl/spsw_if.sv
rtl/spsw_ram.sv
rtl/segmented_prime_sieve_window.sv
test/segmented_prime_sieve_window_tb.sv
